/* rtl/suv_pkg.sv */
// Shared types, constants and helper functions of the sphere UV texel address unit.
package suv_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int DIM_LOG2     = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 23;
    localparam int CFG_W   = 24;
    localparam int DIM_W   = 13;
    localparam int IDX_W   = 3;
    localparam int UV_W    = 16;
    localparam int TEX_W   = 12;
    localparam int ADDR_W  = 24;

    localparam int TURN_W  = 32;
    localparam int ANG_W   = 34;
    localparam int CW      = 36;
    localparam int CLAMP_W = TURN_W + 1;
    localparam int DIV_N   = CLAMP_W + FRAC_BITS;
    localparam int SQ_IN_W = 2 * RAD_W + 16;
    localparam int SQ_N    = SQ_IN_W / 2;
    localparam int DW      = DIM_LOG2 + 1;

    localparam int PIPE_LAT = 7 + SQ_N + CORDIC_N + DIV_N;

    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'h0000_0000_8000_0000);
    localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(64'h0000_0001_0000_0000);
    localparam logic [31:0] DIM_MAX = 32'd1 << DIM_LOG2;

    typedef enum logic [IDX_W-1:0] {
        CFG_TILE_X     = 3'd0,
        CFG_TILE_Y     = 3'd1,
        CFG_OFFSET_U   = 3'd2,
        CFG_OFFSET_V   = 3'd3,
        CFG_TEX_WIDTH  = 3'd4,
        CFG_TEX_HEIGHT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [RAD_W-1:0]          sphere_radius;
    } suv_in_t;

    typedef struct packed {
        logic [UV_W-1:0]   tex_u;
        logic [UV_W-1:0]   tex_v;
        logic [TEX_W-1:0]  texel_col;
        logic [TEX_W-1:0]  texel_row;
        logic [ADDR_W-1:0] texel_address;
    } suv_out_t;

    typedef struct packed {
        logic signed [CW-1:0]    re;
        logic signed [CW-1:0]    im;
        logic signed [ANG_W-1:0] ang;
        logic                    hold;
    } cordic_t;

    typedef struct packed {
        logic [CFG_W-1:0] rem;
        logic [DIV_N-1:0] work;
    } div_t;

    typedef struct packed {
        logic [SQ_IN_W-1:0]        rem;
        logic [SQ_N-1:0]           root;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic                      v_ok;
    } sq_t;

    function automatic logic [TURN_W-1:0] turn_atan(input int i);
        case (i)
            0:  return 32'd536870912;
            1:  return 32'd316933406;
            2:  return 32'd167458907;
            3:  return 32'd85004756;
            4:  return 32'd42667331;
            5:  return 32'd21354465;
            6:  return 32'd10679838;
            7:  return 32'd5340245;
            8:  return 32'd2670163;
            9:  return 32'd1335087;
            10: return 32'd667544;
            11: return 32'd333772;
            12: return 32'd166886;
            13: return 32'd83443;
            14: return 32'd41722;
            15: return 32'd20861;
            16: return 32'd10430;
            17: return 32'd5215;
            18: return 32'd2608;
            19: return 32'd1304;
            20: return 32'd652;
            21: return 32'd326;
            22: return 32'd163;
            23: return 32'd81;
            24: return 32'd41;
            25: return 32'd20;
            26: return 32'd10;
            27: return 32'd5;
            28: return 32'd3;
            29: return 32'd1;
            30: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] scale_coord(input logic signed [COORD_W-1:0] c);
        return $signed({{(CW-COORD_W-8){c[COORD_W-1]}}, c, 8'h00});
    endfunction

    function automatic logic [TURN_W-1:0] off_turn(input logic [CFG_W-1:0] o);
        logic [2*TURN_W-1:0] wide;
        wide = {{(2*TURN_W-CFG_W){o[CFG_W-1]}}, o};
        wide = wide << (TURN_W - FRAC_BITS);
        return wide[TURN_W-1:0];
    endfunction

    function automatic logic [DW-1:0] dim_clamp(input logic [DIM_W-1:0] d);
        logic [31:0] dd;
        dd = 32'(d);
        if (dd == 32'd0) begin
            dd = 32'd1;
        end else if (dd > DIM_MAX) begin
            dd = DIM_MAX;
        end
        return DW'(dd);
    endfunction

endpackage

/* rtl/suv_cordic.sv */
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
module suv_cordic
    import suv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  cordic_t                 in_vec,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] out_ang
);

    cordic_t stage_reg [CORDIC_N];
    logic [CORDIC_N-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[CORDIC_N-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_step
        cordic_t cur;
        cordic_t stage_next;
        logic signed [CW-1:0]    re_sh;
        logic signed [CW-1:0]    im_sh;
        logic signed [ANG_W-1:0] step;

        if (i == 0)
        begin : g_first
            assign cur = in_vec;
        end
        else
        begin : g_rest
            assign cur = stage_reg[i-1];
        end

        assign re_sh = $signed(cur.re) >>> i;
        assign im_sh = $signed(cur.im) >>> i;
        assign step  = $signed({{(ANG_W-TURN_W){1'b0}}, turn_atan(i)});

        always_comb
        begin
            stage_next = cur;
            if (!cur.hold)
            begin
                if (!cur.im[CW-1])
                begin
                    stage_next.re  = cur.re + im_sh;
                    stage_next.im  = cur.im - re_sh;
                    stage_next.ang = cur.ang + step;
                end
                else
                begin
                    stage_next.re  = cur.re - im_sh;
                    stage_next.im  = cur.im + re_sh;
                    stage_next.ang = cur.ang - step;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next;
        end
    end

    assign out_valid = valid_reg[CORDIC_N-1];
    assign out_ang   = stage_reg[CORDIC_N-1].ang;

endmodule

/* rtl/suv_div.sv */
// Pipelined restoring divider for the tiling step, one quotient bit per stage.
module suv_div
    import suv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [CLAMP_W-1:0] in_num,
    input  logic [CFG_W-1:0]   in_den,
    output logic               out_valid,
    output logic [TURN_W-1:0]  out_quot
);

    div_t stage_reg [DIV_N];
    logic [DIV_N-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_N-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < DIV_N; i++)
    begin : g_step
        div_t cur;
        div_t stage_next;
        logic [CFG_W:0] trial;

        if (i == 0)
        begin : g_first
            assign cur = '{rem: '0, work: {in_num, {FRAC_BITS{1'b0}}}};
        end
        else
        begin : g_rest
            assign cur = stage_reg[i-1];
        end

        assign trial = {cur.rem, cur.work[DIV_N-1]};

        always_comb
        begin
            if (trial >= {1'b0, in_den})
            begin
                stage_next.rem  = CFG_W'(trial - {1'b0, in_den});
                stage_next.work = {cur.work[DIV_N-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem  = trial[CFG_W-1:0];
                stage_next.work = {cur.work[DIV_N-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next;
        end
    end

    assign out_valid = valid_reg[DIV_N-1];
    assign out_quot  = stage_reg[DIV_N-1].work[TURN_W-1:0];

endmodule

/* rtl/sphere_uv_texel_address_unit.sv */
// Top level of the sphere UV texel address unit.
//
//   Channel   Handshake                 Payload
//   sample    start / busy              suv_in_t  (point x, y, z, radius)
//   result    done strobe, one cycle    suv_out_t (u, v, column, row, address)
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word is accepted in every cycle; busy stays low and cfg_ready stays high.
// Each word runs through the square-root stages, the CORDIC rotations and the
// tiling divider, one bit or step per stage, between input and output registers.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline advances every cycle.
module sphere_uv_texel_address_unit
    import suv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  suv_in_t          sample,
    output logic             done,
    output suv_out_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] tile_x_reg, tile_y_reg, offset_u_reg, offset_v_reg;
    logic [DIM_W-1:0] tex_width_reg, tex_height_reg;
    logic [DW-1:0]    wd_reg, ht_reg;
    logic [CFG_W-1:0] den_u, den_v;

    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [2*RAD_W-1:0]        s1_r2_reg;
    logic [2*COORD_W-1:0]      s1_y2_reg;
    logic                      s1_vok_reg;
    logic [COORD_W-1:0]        ay;

    logic           s2_valid_reg;
    sq_t            s2_reg;
    logic [2*RAD_W-1:0] diff;

    sq_t            sq_reg [SQ_N];
    logic [SQ_N-1:0] sq_valid_reg;
    sq_t            sq_last;

    cordic_t vec_u, vec_v;
    logic    cu_valid, cv_valid;
    logic signed [ANG_W-1:0] ang_u, ang_v, sum_u, sum_v;

    logic               cl_valid_reg;
    logic [CLAMP_W-1:0] cl_u_reg, cl_v_reg;

    logic              du_valid, dv_valid;
    logic [TURN_W-1:0] quot_u, quot_v;

    logic              q1_valid_reg, q2_valid_reg, q3_valid_reg, done_reg;
    logic [TURN_W-1:0] uf_reg, vf_reg;
    logic [TURN_W+DW-1:0] prod_u, prod_v;
    logic [DIM_LOG2-1:0]  col_reg, row_reg, col3_reg, row3_reg, flip;
    logic [UV_W-1:0]      tu2_reg, tv2_reg, tu3_reg, tv3_reg;
    logic [DIM_LOG2+DW-1:0] mul_reg;
    logic [DIM_LOG2+DW:0]   addr;
    suv_out_t             result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_x_reg     <= CFG_W'(64'd1 << FRAC_BITS);
            tile_y_reg     <= CFG_W'(64'd1 << FRAC_BITS);
            offset_u_reg   <= '0;
            offset_v_reg   <= '0;
            tex_width_reg  <= DIM_W'(256);
            tex_height_reg <= DIM_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TILE_X:     tile_x_reg     <= cfg_data;
                CFG_TILE_Y:     tile_y_reg     <= cfg_data;
                CFG_OFFSET_U:   offset_u_reg   <= cfg_data;
                CFG_OFFSET_V:   offset_v_reg   <= cfg_data;
                CFG_TEX_WIDTH:  tex_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_TEX_HEIGHT: tex_height_reg <= cfg_data[DIM_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        wd_reg <= dim_clamp(tex_width_reg);
        ht_reg <= dim_clamp(tex_height_reg);
    end

    assign den_u = (tile_x_reg == '0) ? CFG_W'(1) : tile_x_reg;
    assign den_v = (tile_y_reg == '0) ? CFG_W'(1) : tile_y_reg;

    // Valid bits of the stages held in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sq_valid_reg <= '0;
            cl_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
            q2_valid_reg <= 1'b0;
            q3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            sq_valid_reg <= {sq_valid_reg[SQ_N-2:0], s2_valid_reg};
            cl_valid_reg <= cu_valid && cv_valid;
            q1_valid_reg <= du_valid && dv_valid;
            q2_valid_reg <= q1_valid_reg;
            q3_valid_reg <= q2_valid_reg;
            done_reg     <= q3_valid_reg;
        end
    end

    assign ay = sample.point_y[COORD_W-1] ? COORD_W'(-sample.point_y)
                                          : COORD_W'(sample.point_y);

    always_ff @(posedge clk)
    begin
        s1_px_reg  <= sample.point_x;
        s1_py_reg  <= sample.point_y;
        s1_pz_reg  <= sample.point_z;
        s1_r2_reg  <= sample.sphere_radius * sample.sphere_radius;
        s1_y2_reg  <= ay * ay;
        s1_vok_reg <= (sample.sphere_radius != '0) && (ay <= COORD_W'(sample.sphere_radius));
    end

    assign diff = s1_r2_reg - s1_y2_reg[2*RAD_W-1:0];

    always_ff @(posedge clk)
    begin
        s2_reg.rem  <= s1_vok_reg ? {diff, 16'h0000} : '0;
        s2_reg.root <= '0;
        s2_reg.px   <= s1_px_reg;
        s2_reg.py   <= s1_py_reg;
        s2_reg.pz   <= s1_pz_reg;
        s2_reg.v_ok <= s1_vok_reg;
    end

    // Integer square root, one result bit per stage from the top down.
    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sqrt
        localparam int K = SQ_N - 1 - j;
        sq_t cur;
        sq_t sq_next;
        logic [SQ_IN_W:0] trial;

        if (j == 0)
        begin : g_first
            assign cur = s2_reg;
        end
        else
        begin : g_rest
            assign cur = sq_reg[j-1];
        end

        assign trial = ((SQ_IN_W+1)'(cur.root) << (K + 1)) + ((SQ_IN_W+1)'(1) << (2 * K));

        always_comb
        begin
            sq_next = cur;
            if ({1'b0, cur.rem} >= trial)
            begin
                sq_next.rem  = SQ_IN_W'({1'b0, cur.rem} - trial);
                sq_next.root = cur.root | (SQ_N'(1) << K);
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[j] <= sq_next;
        end
    end

    assign sq_last = sq_reg[SQ_N-1];

    always_comb
    begin
        vec_u = '{re: '0, im: '0, ang: '0, hold: 1'b1};
        if (sq_last.px == '0 && sq_last.pz == '0)
        begin
            vec_u = '{re: '0, im: '0, ang: '0, hold: 1'b1};
        end
        else if (sq_last.pz[COORD_W-1])
        begin
            vec_u.re   = -scale_coord(sq_last.pz);
            vec_u.im   = -scale_coord(sq_last.px);
            vec_u.ang  = sq_last.px[COORD_W-1] ? -HALF_TURN : HALF_TURN;
            vec_u.hold = 1'b0;
        end
        else
        begin
            vec_u.re   = scale_coord(sq_last.pz);
            vec_u.im   = scale_coord(sq_last.px);
            vec_u.ang  = '0;
            vec_u.hold = 1'b0;
        end
    end

    // A point off the sphere holds a quarter turn back, which clamps v to zero.
    always_comb
    begin
        if (sq_last.v_ok)
        begin
            vec_v.re   = $signed(CW'(sq_last.root));
            vec_v.im   = scale_coord(sq_last.py);
            vec_v.ang  = '0;
            vec_v.hold = 1'b0;
        end
        else
        begin
            vec_v.re   = '0;
            vec_v.im   = '0;
            vec_v.ang  = -(HALF_TURN >>> 1);
            vec_v.hold = 1'b1;
        end
    end

    suv_cordic u_cordic_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid_reg[SQ_N-1]),
        .in_vec    (vec_u),
        .out_valid (cu_valid),
        .out_ang   (ang_u)
    );

    suv_cordic u_cordic_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid_reg[SQ_N-1]),
        .in_vec    (vec_v),
        .out_valid (cv_valid),
        .out_ang   (ang_v)
    );

    assign sum_u = ang_u + HALF_TURN;
    assign sum_v = HALF_TURN + (ang_v <<< 1);

    always_ff @(posedge clk)
    begin
        if (sum_u[ANG_W-1])
        begin
            cl_u_reg <= '0;
        end
        else if (sum_u > FULL_TURN)
        begin
            cl_u_reg <= FULL_TURN[CLAMP_W-1:0];
        end
        else
        begin
            cl_u_reg <= sum_u[CLAMP_W-1:0];
        end

        if (sum_v[ANG_W-1])
        begin
            cl_v_reg <= '0;
        end
        else if (sum_v > FULL_TURN)
        begin
            cl_v_reg <= FULL_TURN[CLAMP_W-1:0];
        end
        else
        begin
            cl_v_reg <= sum_v[CLAMP_W-1:0];
        end
    end

    suv_div u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cl_valid_reg),
        .in_num    (cl_u_reg),
        .in_den    (den_u),
        .out_valid (du_valid),
        .out_quot  (quot_u)
    );

    suv_div u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cl_valid_reg),
        .in_num    (cl_v_reg),
        .in_den    (den_v),
        .out_valid (dv_valid),
        .out_quot  (quot_v)
    );

    assign prod_u = uf_reg * wd_reg;
    assign prod_v = vf_reg * ht_reg;
    assign flip   = DIM_LOG2'(ht_reg - DW'(1) - DW'(row_reg));
    assign addr   = (DIM_LOG2+DW+1)'(mul_reg) + (DIM_LOG2+DW+1)'(col3_reg);

    always_ff @(posedge clk)
    begin
        uf_reg   <= quot_u + off_turn(offset_u_reg);
        vf_reg   <= quot_v + off_turn(offset_v_reg);
        col_reg  <= prod_u[TURN_W +: DIM_LOG2];
        row_reg  <= prod_v[TURN_W +: DIM_LOG2];
        tu2_reg  <= uf_reg[TURN_W-1 -: UV_W];
        tv2_reg  <= vf_reg[TURN_W-1 -: UV_W];
        mul_reg  <= flip * wd_reg;
        col3_reg <= col_reg;
        row3_reg <= row_reg;
        tu3_reg  <= tu2_reg;
        tv3_reg  <= tv2_reg;
        result_reg.tex_u         <= tu3_reg;
        result_reg.tex_v         <= tv3_reg;
        result_reg.texel_col     <= TEX_W'(col3_reg);
        result_reg.texel_row     <= TEX_W'(row3_reg);
        result_reg.texel_address <= ADDR_W'(addr);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/suv_checker.sv */
// Port-level checker of the sphere UV texel address unit and its bind.
module suv_checker
    import suv_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input logic     cfg_ready
);

    // The pipeline takes a new word in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready dropped");

    // Every result strobe belongs to a word accepted a fixed latency earlier.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without matching word");

    a_done_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done)
        else $error("result right after reset");

endmodule

bind sphere_uv_texel_address_unit suv_checker u_suv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);

/* dv/suv_texel_checker.sv */
// Checker for the sphere UV texel address unit: predicts each word and compares results.
module suv_texel_checker
    import suv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  suv_in_t          sample,
    input  logic             done,
    input  suv_out_t         result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0]        tile_x;
    logic [CFG_W-1:0]        tile_y;
    logic signed [CFG_W-1:0] offset_u;
    logic signed [CFG_W-1:0] offset_v;
    logic [DIM_W-1:0]        tex_width;
    logic [DIM_W-1:0]        tex_height;
    suv_out_t                texel_queue[$];

    localparam longint HALF_T = 64'sd1 << 31;
    localparam longint FULL_T = 64'sd1 << 32;

    function automatic longint cordic_turns(input longint re_in, input longint im_in);
        longint re;
        longint im;
        longint ang;
        longint dr;
        longint di;
        re = re_in;
        im = im_in;
        ang = 0;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            dr = im >>> i;
            di = re >>> i;
            if (im >= 0)
            begin
                re += dr;
                im -= di;
                ang += longint'(turn_atan(i));
            end
            else
            begin
                re -= dr;
                im += di;
                ang -= longint'(turn_atan(i));
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned res;
        longint unsigned bitv;
        n = n_in;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned clamp_turns(input longint a);
        if (a < 0)
            return 0;
        if (a > FULL_T)
            return FULL_T;
        return a;
    endfunction

    function automatic logic [31:0] tile_wrap(input longint unsigned c,
                                              input logic [CFG_W-1:0] tile,
                                              input logic signed [CFG_W-1:0] off);
        longint unsigned t;
        longint unsigned q;
        longint s;
        t = (tile == 0) ? 1 : tile;
        q = (c << FRAC_BITS) / t;
        s = longint'(q) + longint'(off) * (64'sd1 << (32 - FRAC_BITS));
        return s[31:0];
    endfunction

    function automatic longint unsigned dim_of(input logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > (1 << DIM_LOG2))
            return 1 << DIM_LOG2;
        return d;
    endfunction

    function automatic suv_out_t texel_of(input suv_in_t s);
        longint px;
        longint py;
        longint pz;
        longint unsigned r;
        longint unsigned ay;
        longint unsigned root;
        longint ang;
        longint unsigned uc;
        longint unsigned vc;
        longint unsigned uf;
        longint unsigned vf;
        longint unsigned w;
        longint unsigned h;
        longint unsigned col;
        longint unsigned row;
        longint unsigned addr;
        suv_out_t o;
        px = longint'(s.point_x) * 256;
        py = longint'(s.point_y);
        pz = longint'(s.point_z) * 256;
        r = s.sphere_radius;
        ay = (py < 0) ? -py : py;
        if (px == 0 && pz == 0)
            ang = 0;
        else if (pz < 0)
            ang = ((px >= 0) ? HALF_T : -HALF_T) + cordic_turns(-pz, -px);
        else
            ang = cordic_turns(pz, px);
        uc = clamp_turns(ang + HALF_T);
        if (r == 0 || ay > r)
            vc = 0;
        else
        begin
            root = int_sqrt((r * r - ay * ay) << 16);
            vc = clamp_turns(HALF_T + 2 * cordic_turns(longint'(root), py * 256));
        end
        uf = tile_wrap(uc, tile_x, offset_u);
        vf = tile_wrap(vc, tile_y, offset_v);
        w = dim_of(tex_width);
        h = dim_of(tex_height);
        col = (uf * w) >> 32;
        row = (vf * h) >> 32;
        addr = (h - 1 - row) * w + col;
        o.tex_u = uf[31:16];
        o.tex_v = vf[31:16];
        o.texel_col = col[TEX_W-1:0];
        o.texel_row = row[TEX_W-1:0];
        o.texel_address = addr[ADDR_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        suv_out_t want;
        if (!rst_n)
        begin
            tile_x <= 24'd1 << FRAC_BITS;
            tile_y <= 24'd1 << FRAC_BITS;
            offset_u <= '0;
            offset_v <= '0;
            tex_width <= 13'd256;
            tex_height <= 13'd256;
        end
        else
        begin
            if (start && !busy)
                texel_queue.push_back(texel_of(sample));
            if (done)
            begin
                if (texel_queue.size() == 0)
                begin
                    $display("%0t: result word with no expectation waiting", $realtime);
                    errors++;
                end
                else
                begin
                    want = texel_queue.pop_front();
                    checked++;
                    if (result.tex_u != want.tex_u)
                        report_mismatch("tex_u", result.tex_u, want.tex_u);
                    if (result.tex_v != want.tex_v)
                        report_mismatch("tex_v", result.tex_v, want.tex_v);
                    if (result.texel_col != want.texel_col)
                        report_mismatch("texel_col", result.texel_col, want.texel_col);
                    if (result.texel_row != want.texel_row)
                        report_mismatch("texel_row", result.texel_row, want.texel_row);
                    if (result.texel_address != want.texel_address)
                        report_mismatch("texel_address", result.texel_address,
                                        want.texel_address);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TILE_X:     tile_x <= cfg_data;
                    CFG_TILE_Y:     tile_y <= cfg_data;
                    CFG_OFFSET_U:   offset_u <= cfg_data;
                    CFG_OFFSET_V:   offset_v <= cfg_data;
                    CFG_TEX_WIDTH:  tex_width <= cfg_data[DIM_W-1:0];
                    CFG_TEX_HEIGHT: tex_height <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
        pending <= texel_queue.size();
    end

    initial
    begin
        errors = 0;
        checked = 0;
        pending = 0;
    end
endmodule

/* dv/tb_sphere_uv_texel_address_unit.sv */
// Testbench top for the sphere UV texel address unit: clock, reset, stimulus and verdict.
module tb_sphere_uv_texel_address_unit;
    import suv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 4 * PIPE_LAT + 1000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    suv_in_t          sample;
    logic             done;
    suv_out_t         result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             busy_seen;
    logic             ready_seen;
    logic             allow_idle;
    int               errors;
    int               pending;
    int               checked;
    int               words_sent;
    int               cfg_writes;
    int               stall_count;

    sphere_uv_texel_address_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    suv_texel_checker u_texel_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
        .pending(pending), .checked(checked)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        busy_seen <= busy;
        ready_seen <= cfg_ready;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic maybe_idle();
        if (allow_idle && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic send_word(input suv_in_t w);
        maybe_idle();
        start <= 1'b1;
        sample <= w;
        @(posedge clk);
        while (busy_seen)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!ready_seen)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [CFG_W-1:0] tx, input logic [CFG_W-1:0] ty,
                             input logic [CFG_W-1:0] ou, input logic [CFG_W-1:0] ov,
                             input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_reg(CFG_TILE_X, tx);
        write_reg(CFG_TILE_Y, ty);
        write_reg(CFG_OFFSET_U, ou);
        write_reg(CFG_OFFSET_V, ov);
        write_reg(CFG_TEX_WIDTH, w);
        write_reg(CFG_TEX_HEIGHT, h);
    endtask

    function automatic suv_in_t make_point(input int x, input int y, input int z, input int r);
        suv_in_t p;
        p.point_x = x[COORD_W-1:0];
        p.point_y = y[COORD_W-1:0];
        p.point_z = z[COORD_W-1:0];
        p.sphere_radius = r[RAD_W-1:0];
        return p;
    endfunction

    function automatic int rand_coord();
        int c;
        c = $urandom_range(0, 24'hFFFFFF) - 24'h800000;
        return c >>> $urandom_range(0, 16);
    endfunction

    function automatic suv_in_t random_point();
        int sel;
        int r;
        int y;
        sel = $urandom_range(0, 99);
        r = $urandom_range(1, 23'h7FFFFF) >> $urandom_range(0, 20);
        if (r == 0)
            r = 1;
        if (sel < 80)
            y = $urandom_range(0, 2 * r) - r;
        else if (sel < 88)
        begin
            y = r + 1 + ($urandom_range(0, 23'h7FFFFF - r) >> $urandom_range(0, 20));
            if ($urandom_range(0, 1))
                y = -y;
        end
        else if (sel < 93)
        begin
            r = 0;
            y = rand_coord();
        end
        else
            return make_point($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                              $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 23'h7FFFFF));
        if (sel == 79)
            return make_point(0, y, 0, r);
        return make_point(rand_coord(), y, rand_coord(), r);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TILE_X;
        cfg_data = '0;
        allow_idle = 1'b1;
        words_sent = 0;
        cfg_writes = 0;
        stall_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_point(0, 0, 0, 65536));
        send_word(make_point(0, 65536, 0, 65536));
        send_word(make_point(0, -65536, 0, 65536));
        send_word(make_point(65536, 0, 0, 65536));
        send_word(make_point(-65536, 0, 0, 65536));
        send_word(make_point(0, 0, -65536, 65536));
        send_word(make_point(65536, 0, -65536, 65536));
        send_word(make_point(-65536, 0, -65536, 65536));
        send_word(make_point(-1, 0, -1, 1));
        send_word(make_point(100, 50, 100, 0));
        send_word(make_point(100, 70000, 100, 65536));
        send_word(make_point(100, -70000, 100, 65536));
        send_word(make_point(-8388608, -8388608, -8388608, 8388607));
        send_word(make_point(8388607, 8388607, 8388607, 8388607));
        send_word(make_point(8388607, -8388607, -8388608, 8388607));
        send_word(make_point(-8388608, 0, 8388607, 0));
        send_word(make_point(0, 8388607, 1, 8388607));
        send_word(make_point(0, -8388608, -1, 8388607));

        write_all(24'd0, 24'd0, 24'h800000, 24'h7FFFFF, 24'd0, 24'd0);
        send_word(make_point(65536, 30000, 65536, 65536));
        send_word(make_point(-65536, -30000, 65536, 65536));
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'd8191, 24'd8191);
        send_word(make_point(65536, 30000, -65536, 65536));
        send_word(make_point(-8388608, 8388607, 8388607, 8388607));
        settle();
        write_reg(CFG_SPARE_6, 24'd1);
        write_reg(CFG_SPARE_7, 24'hFFFFFF);
        send_word(make_point(12345, 678, -9999, 4096));

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_all(24'h010000, 24'h010000, 24'd0, 24'd0, 24'd256, 24'd256);
                1: write_all(24'd1, 24'd1, 24'h800000, 24'h800000, 24'd1, 24'd1);
                2: write_all(24'hFFFFFF, 24'h008000, 24'h7FFFFF, 24'h7FFFFF, 24'd4096, 24'd4096);
                3: write_all(24'h028000, 24'h030000, 24'h004000, 24'hFFC000, 24'd640, 24'd480);
                4: write_all(CFG_W'($urandom_range(0, 24'hFFFFFF)),
                             CFG_W'($urandom_range(0, 24'hFFFFFF)),
                             CFG_W'($urandom_range(0, 24'hFFFFFF)),
                             CFG_W'($urandom_range(0, 24'hFFFFFF)),
                             CFG_W'($urandom_range(0, 13'h1FFF)),
                             CFG_W'($urandom_range(0, 13'h1FFF)));
                default: write_all(CFG_W'($urandom_range(1, 24'h040000)),
                                   CFG_W'($urandom_range(1, 24'h040000)),
                                   CFG_W'($urandom_range(0, 24'hFFFFFF)),
                                   CFG_W'($urandom_range(0, 24'hFFFFFF)),
                                   CFG_W'($urandom_range(1, 4096)),
                                   CFG_W'($urandom_range(1, 4096)));
            endcase
            if (phase == 5)
                allow_idle = 1'b0;
            repeat (190) send_word(random_point());
        end

        settle();
        repeat (PIPE_LAT + 20) @(posedge clk);
        $display("Sent %0d sample words across 8 register settings (%0d register writes).",
                 words_sent, cfg_writes);
        $display("Checked %0d result words; %0d still outstanding.", checked, pending);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* sphere_uv_texel_address_unit.f */
rtl/suv_pkg.sv
rtl/suv_cordic.sv
rtl/suv_div.sv
rtl/sphere_uv_texel_address_unit.sv
rtl/suv_checker.sv
dv/suv_texel_checker.sv
dv/tb_sphere_uv_texel_address_unit.sv
